// File: design/asi_pkg.sv
`timescale 1ns / 1ps
package asi_pkg;

   localparam int SampleWidth = 32;
   localparam int OutWidth    = 16;
   localparam int CsrIdxWidth = 2;
   localparam int CsrWidth    = 6;
   localparam int ProdWidth   = 39;
   localparam int MantWidth   = 25;

   localparam logic [14:0] FloatScale = 15'd32767;
   localparam logic [8:0]  ExpOffset  = 9'd150;
   localparam logic [5:0]  ValidReset = 6'd16;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_ENCODING  = 2'd0,
      CSR_CONTAINER = 2'd1,
      CSR_VALIDBITS = 2'd2
   } csr_idx_type;

   typedef enum logic [2:0] {
      KIND_PCM,
      KIND_ZERO,
      KIND_POS,
      KIND_NEG,
      KIND_CALC
   } kind_type;

   typedef struct packed {
      logic       encoding;
      logic [1:0] container_code;
      logic [5:0] valid_bits;
   } cfg_type;

   typedef struct packed {
      kind_type               kind;
      logic                   sign;
      logic [7:0]             expo;
      logic [ProdWidth-1:0]   prod;
      logic [OutWidth-1:0]    pcm;
   } front_type;

   typedef struct packed {
      kind_type               kind;
      logic                   sign;
      logic [MantWidth-1:0]   mant;
      logic [7:0]             shift;
      logic [OutWidth-1:0]    pcm;
   } round_type;

   typedef struct packed {
      logic valid;
      logic ready;
   } hs_type;

endpackage

// File: design/asi_if.sv
`timescale 1ns / 1ps
interface asi_req_if import asi_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [SampleWidth-1:0] sample_word;
   modport source (output valid, output sample_word, input ready);
   modport sink   (input valid, input sample_word, output ready);
endinterface

interface asi_rsp_if import asi_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [OutWidth-1:0] sample_out;
   modport source (output valid, output sample_out, input ready);
   modport sink   (input valid, input sample_out, output ready);
endinterface

// File: design/asi_front.sv
`timescale 1ns / 1ps
module asi_front import asi_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  cfg_type                cfg,
   input  logic                   in_valid,
   input  logic [SampleWidth-1:0] in_word,
   input  logic                   down_ready,
   output hs_type                 hs,
   output front_type              data_ff
);

   logic        valid_ff;
   logic        valid_in;
   logic        load;
   front_type   data_in;
   logic [5:0]  cw;
   logic [5:0]  vb;
   logic [31:0] sext;
   logic signed [31:0] tmp;
   logic [23:0] mant24;
   logic [7:0]  expo;

   assign hs.valid = valid_ff;
   assign hs.ready = !valid_ff || down_ready;
   assign load     = in_valid && hs.ready;
   assign valid_in = load ? 1'b1 : (down_ready ? 1'b0 : valid_ff);

   always_comb begin
      case (cfg.container_code)
         2'd0: begin
            cw   = 6'd16;
            sext = {{16{in_word[15]}}, in_word[15:0]};
         end
         2'd1: begin
            cw   = 6'd24;
            sext = {{8{in_word[23]}}, in_word[23:0]};
         end
         default: begin
            cw   = 6'd32;
            sext = in_word;
         end
      endcase
      vb = cfg.valid_bits;
      if (vb > cw) vb = cw;
      if (vb < 6'd8) vb = 6'd8;
      tmp = $signed(sext) >>> (cw - vb);
      if (vb < 6'd16) tmp = tmp <<< (6'd16 - vb);
      else            tmp = tmp >>> (vb - 6'd16);

      expo   = in_word[30:23];
      mant24 = {1'b1, in_word[22:0]};

      data_in.pcm  = tmp[OutWidth-1:0];
      data_in.sign = in_word[31];
      data_in.expo = expo;
      data_in.prod = ProdWidth'(mant24) * ProdWidth'(FloatScale);
      if (!cfg.encoding)          data_in.kind = KIND_PCM;
      else if (expo == 8'hFF)     data_in.kind = KIND_ZERO;
      else if (expo >= 8'd127)    data_in.kind = in_word[31] ? KIND_NEG : KIND_POS;
      else if (expo == 8'd0)      data_in.kind = KIND_ZERO;
      else                        data_in.kind = KIND_CALC;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
      if (load)  data_ff  <= data_in;
   end

endmodule

// File: design/asi_round.sv
`timescale 1ns / 1ps
module asi_round import asi_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   input  front_type in_data,
   input  logic      down_ready,
   output hs_type    hs,
   output round_type data_ff
);

   logic                 valid_ff;
   logic                 valid_in;
   logic                 load;
   round_type            data_in;
   logic [3:0]           sh;
   logic [23:0]          keep;
   logic [ProdWidth-1:0] rem;
   logic [ProdWidth-1:0] half;
   logic                 up;
   logic [8:0]           shift_w;

   assign hs.valid = valid_ff;
   assign hs.ready = !valid_ff || down_ready;
   assign load     = in_valid && hs.ready;
   assign valid_in = load ? 1'b1 : (down_ready ? 1'b0 : valid_ff);

   always_comb begin
      sh      = in_data.prod[ProdWidth-1] ? 4'd15 : 4'd14;
      keep    = 24'(in_data.prod >> sh);
      half    = ProdWidth'(1) << (sh - 4'd1);
      rem     = in_data.prod & ((ProdWidth'(1) << sh) - ProdWidth'(1));
      up      = (rem > half) || ((rem == half) && keep[0]);
      shift_w = ExpOffset - {1'b0, in_data.expo} - 9'(sh);
      data_in.kind  = in_data.kind;
      data_in.sign  = in_data.sign;
      data_in.pcm   = in_data.pcm;
      data_in.mant  = MantWidth'(keep) + MantWidth'(up);
      data_in.shift = shift_w[7:0];
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
      if (load)  data_ff  <= data_in;
   end

endmodule

// File: design/asi_finish.sv
`timescale 1ns / 1ps
module asi_finish import asi_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  round_type                  in_data,
   input  logic                       down_ready,
   output hs_type                     hs,
   output logic signed [OutWidth-1:0] sample_ff
);

   logic                       valid_ff;
   logic                       valid_in;
   logic                       load;
   logic signed [OutWidth-1:0] sample_in;
   logic [MantWidth:0]         sum;
   logic [OutWidth-1:0]        mag;

   assign hs.valid = valid_ff;
   assign hs.ready = !valid_ff || down_ready;
   assign load     = in_valid && hs.ready;
   assign valid_in = load ? 1'b1 : (down_ready ? 1'b0 : valid_ff);

   always_comb begin
      sum = (MantWidth+1)'(in_data.mant)
          + ((MantWidth+1)'(1) << (in_data.shift[4:0] - 5'd1));
      mag = 16'(sum >> in_data.shift[4:0]);
      if (in_data.shift >= 8'd26) mag = '0;
      case (in_data.kind)
         KIND_PCM:  sample_in = in_data.pcm;
         KIND_POS:  sample_in = 16'sh7FFF;
         KIND_NEG:  sample_in = 16'sh8000;
         KIND_CALC: sample_in = in_data.sign ? -$signed(mag) : $signed(mag);
         default:   sample_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff  <= 1'b0;
      else       valid_ff  <= valid_in;
      if (load)  sample_ff <= sample_in;
   end

endmodule

// File: design/audio_sample_to_int16_top.sv
`timescale 1ns / 1ps
// Converts one raw sample container word per beat into a signed 16-bit sample, either from
// 16/24/32-bit integer PCM or from IEEE single float. A new beat is taken every cycle unless
// the output side stalls the pipeline; each result passes through the three register stages
// (container decode and 24x15 multiply, single-precision rounding, final scaling and
// rounding). Write the csr_ registers only while no beat is in flight.
module audio_sample_to_int16_top import asi_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   asi_req_if.sink                req_ch,
   asi_rsp_if.source              rsp_ch,
   input  logic                   csr_write_en,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [CsrWidth-1:0]    csr_wdata
);

   cfg_type   cfg_ff;
   hs_type    front_hs;
   hs_type    round_hs;
   hs_type    finish_hs;
   front_type front_data;
   round_type round_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.encoding       <= 1'b0;
         cfg_ff.container_code <= 2'd0;
         cfg_ff.valid_bits     <= ValidReset;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_ENCODING:  cfg_ff.encoding       <= csr_wdata[0];
            CSR_CONTAINER: cfg_ff.container_code <= csr_wdata[1:0];
            CSR_VALIDBITS: cfg_ff.valid_bits     <= csr_wdata;
            default: ;
         endcase
      end
   end

   asi_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .in_valid   (req_ch.valid),
      .in_word    (req_ch.sample_word),
      .down_ready (round_hs.ready),
      .hs         (front_hs),
      .data_ff    (front_data)
   );

   asi_round u_round (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (front_hs.valid),
      .in_data    (front_data),
      .down_ready (finish_hs.ready),
      .hs         (round_hs),
      .data_ff    (round_data)
   );

   asi_finish u_finish (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (round_hs.valid),
      .in_data    (round_data),
      .down_ready (rsp_ch.ready),
      .hs         (finish_hs),
      .sample_ff  (rsp_ch.sample_out)
   );

   assign req_ch.ready = front_hs.ready;
   assign rsp_ch.valid = finish_hs.valid;

   a_front_hold: assert property (@(posedge clock) disable iff (reset)
      front_hs.valid && !round_hs.ready |=> front_hs.valid && $stable(front_data))
      else $error("front stage lost a stalled beat");

   a_round_hold: assert property (@(posedge clock) disable iff (reset)
      round_hs.valid && !finish_hs.ready |=> round_hs.valid && $stable(round_data))
      else $error("round stage lost a stalled beat");

   a_pcm_kind: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready && !cfg_ff.encoding |=> front_data.kind == KIND_PCM)
      else $error("integer beat took the float path");

endmodule

// File: sim/audio_sample_to_int16_top_tb.sv
`timescale 1ns / 1ps
module audio_sample_to_int16_top_tb;
   import asi_pkg::*;

   localparam int CycleLimit = 400000;

   logic                   clock;
   logic                   reset;
   logic                   csr_write_en;
   logic [CsrIdxWidth-1:0] csr_index;
   logic [CsrWidth-1:0]    csr_wdata;

   asi_req_if req_ch ();
   asi_rsp_if rsp_ch ();

   audio_sample_to_int16_top u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_ch       (req_ch),
      .rsp_ch       (rsp_ch),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   logic [31:0]                pending_words[$];
   logic signed [OutWidth-1:0] expected_samples[$];
   logic                       mode_encoding;
   logic [1:0]                 mode_container;
   logic [5:0]                 mode_valid_bits;
   int                         mismatch_count;
   int                         cycle_count;
   int                         send_gap;
   int                         recv_stall;
   bit                         send_idle_on;
   bit                         recv_idle_on;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic logic signed [OutWidth-1:0] pcm_sample(logic [31:0] w);
      longint s;
      int     cw;
      int     vb;
      case (mode_container)
         2'd0: begin
            cw = 16;
            s  = longint'($signed(w[15:0]));
         end
         2'd1: begin
            cw = 24;
            s  = longint'($signed(w[23:0]));
         end
         default: begin
            cw = 32;
            s  = longint'($signed(w));
         end
      endcase
      vb = int'(mode_valid_bits);
      if (vb > cw) vb = cw;
      if (vb < 8) vb = 8;
      s = s >>> (cw - vb);
      if (vb > 16) s = s >>> (vb - 16);
      else s = s <<< (16 - vb);
      if (s < -32768) s = -32768;
      if (s > 32767) s = 32767;
      return s[15:0];
   endfunction

   function automatic logic signed [OutWidth-1:0] float_sample(logic [31:0] w);
      longint unsigned prod;
      longint unsigned mant;
      longint unsigned rem;
      longint unsigned half;
      longint          q;
      int              n;
      int              sh;
      int              ee;
      int              t;
      if (w[30:23] == 8'hFF) return 16'sd0;
      if (w[30:23] >= 8'd127) return w[31] ? -16'sd32768 : 16'sd32767;
      mant = 64'({w[30:23] != 8'd0, w[22:0]});
      ee   = (w[30:23] == 8'd0) ? 1 : int'(w[30:23]);
      prod = mant * 64'd32767;
      if (prod == 0) return 16'sd0;
      n = 0;
      while ((prod >> n) != 0) n++;
      sh = 0;
      if (n > 24) begin
         sh   = n - 24;
         mant = prod >> sh;
         rem  = prod & ((64'd1 << sh) - 1);
         half = 64'd1 << (sh - 1);
         if (rem > half || (rem == half && mant[0])) mant++;
      end else begin
         mant = prod;
      end
      t = sh + ee - 150;
      if (t >= 0) q = longint'(mant << t);
      else if (-t >= 63) q = 0;
      else q = longint'((mant >> (-t)) + ((mant >> (-t - 1)) & 64'd1));
      if (w[31]) q = -q;
      return q[15:0];
   endfunction

   function automatic logic [31:0] random_word();
      logic [31:0] w;
      w = $urandom;
      if (mode_encoding) begin
         case ($urandom_range(0, 9))
            0: ;
            1: w[30:23] = 8'hFF;
            2: w[30:23] = 8'd0;
            default: w[30:23] = 8'($urandom_range(100, 127));
         endcase
      end else if ($urandom_range(0, 3) == 0) begin
         w[31:8] = {24{w[0]}};
      end
      return w;
   endfunction

   task automatic report_mismatch(logic signed [OutWidth-1:0] got,
                                  logic signed [OutWidth-1:0] want);
      $display("mismatch: sample_out %0d, expected %0d", got, want);
      mismatch_count++;
   endtask

   task automatic write_csr(csr_idx_type idx, logic [5:0] value);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      case (idx)
         CSR_ENCODING:  mode_encoding   = value[0];
         CSR_CONTAINER: mode_container  = value[1:0];
         default:       mode_valid_bits = value;
      endcase
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_words.size() != 0 || expected_samples.size() != 0 || req_ch.valid)
         @(negedge clock);
      repeat (6) @(posedge clock);
   endtask

   // driver
   always @(posedge clock) begin
      logic        busy;
      logic        nv;
      logic [31:0] w;
      cycle_count <= cycle_count + 1;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         busy = req_ch.valid && !req_ch.ready;
         if (req_ch.valid && req_ch.ready)
            expected_samples.push_back(mode_encoding ? float_sample(req_ch.sample_word)
                                                     : pcm_sample(req_ch.sample_word));
         if (!busy) begin
            nv = 1'b0;
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_words.size() != 0) begin
               w  = pending_words.pop_front();
               nv = 1'b1;
               req_ch.sample_word <= w;
               if ($urandom_range(0, 49) == 0) send_idle_on = !send_idle_on;
               send_gap = send_idle_on ? $urandom_range(0, 9) : 0;
            end
            req_ch.valid <= nv;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      logic signed [OutWidth-1:0] want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_samples.size() == 0) begin
               $display("unexpected beat: sample_out %0d", rsp_ch.sample_out);
               mismatch_count++;
            end else begin
               want = expected_samples.pop_front();
               if (rsp_ch.sample_out !== want) report_mismatch(rsp_ch.sample_out, want);
            end
            if ($urandom_range(0, 49) == 0) recv_idle_on = !recv_idle_on;
            recv_stall = recv_idle_on ? $urandom_range(0, 9) : 0;
         end
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
      if (cycle_count > CycleLimit) begin
         $display("timeout");
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      logic [31:0] pcm_edges[$];
      logic [31:0] float_edges[$];
      logic [5:0]  fixed_cfg[$];
      logic [5:0]  enc;
      logic [5:0]  cont;
      logic [5:0]  vb;
      reset           = 1'b1;
      csr_write_en    = 1'b0;
      csr_index       = CSR_ENCODING;
      csr_wdata       = '0;
      req_ch.valid    = 1'b0;
      req_ch.sample_word = '0;
      rsp_ch.ready    = 1'b0;
      mode_encoding   = 1'b0;
      mode_container  = 2'd0;
      mode_valid_bits = ValidReset;
      mismatch_count  = 0;
      cycle_count     = 0;
      send_gap        = 0;
      recv_stall      = 0;
      send_idle_on    = 1'b1;
      recv_idle_on    = 1'b1;
      pcm_edges   = '{32'h0, 32'h7FFF, 32'h8000, 32'hFFFF, 32'hFFFF_FFFF, 32'h1234_8000,
                      32'h7FFF_FFFF, 32'h8000_0000, 32'h0080_0000};
      float_edges = '{32'h3F80_0000, 32'hBF80_0000, 32'h7F80_0000, 32'hFF80_0000,
                      32'h7FC0_0000, 32'h8000_0000, 32'h0000_0000, 32'h3F00_0000,
                      32'hBF00_0000, 32'h0000_0001, 32'h3F7F_FFFF, 32'hBF7F_FFFF,
                      32'h3800_0000};
      // encoding, container, valid bits
      fixed_cfg = '{6'd0, 6'd0, 6'd8,   6'd0, 6'd2, 6'd32,  6'd0, 6'd1, 6'd24,
                    6'd0, 6'd3, 6'd63,  6'd0, 6'd0, 6'd0,   6'd1, 6'd3, 6'd63,
                    6'd0, 6'd2, 6'd8,   6'd1, 6'd0, 6'd16};
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      foreach (pcm_edges[i]) pending_words.push_back(pcm_edges[i]);
      wait_drained();
      for (int p = 0; p < 12; p++) begin
         if (p < 8) begin
            enc  = fixed_cfg[3*p];
            cont = fixed_cfg[3*p+1];
            vb   = fixed_cfg[3*p+2];
         end else begin
            enc  = 6'($urandom);
            cont = 6'($urandom);
            vb   = 6'($urandom_range(0, 40));
         end
         write_csr(CSR_ENCODING, enc);
         write_csr(CSR_CONTAINER, cont);
         write_csr(CSR_VALIDBITS, vb);
         if (mode_encoding && p == 5) begin
            foreach (float_edges[i]) pending_words.push_back(float_edges[i]);
         end else if (!mode_encoding && p < 5) begin
            foreach (pcm_edges[i]) pending_words.push_back(pcm_edges[i]);
         end
         for (int i = 0; i < 125; i++) pending_words.push_back(random_word());
         wait_drained();
      end
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
